// ===== rtl/rfae_pkg.sv =====
// ----------------------------------------------------------------------------
// rfae_pkg
// Shared types and constants of the register file ALU executor: opcodes,
// status codes and the request and result payloads.
// ----------------------------------------------------------------------------
package rfae_pkg;

	localparam int DATA_W  = 32;
	localparam int FIELD_W = 8;

	// Opcode bytes: high nibble selects the operation, low nibble the form.
	localparam logic [FIELD_W-1:0] OP_SET   = 8'h00;
	localparam logic [FIELD_W-1:0] OP_ADD_R = 8'h10;
	localparam logic [FIELD_W-1:0] OP_ADD_I = 8'h11;
	localparam logic [FIELD_W-1:0] OP_SUB_R = 8'h20;
	localparam logic [FIELD_W-1:0] OP_SUB_I = 8'h21;
	localparam logic [FIELD_W-1:0] OP_MUL_R = 8'h30;
	localparam logic [FIELD_W-1:0] OP_MUL_I = 8'h31;
	localparam logic [FIELD_W-1:0] OP_DIV_R = 8'h40;
	localparam logic [FIELD_W-1:0] OP_DIV_I = 8'h41;

	// Status reported with every result.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BADOP = 2'd1,
		ST_RANGE = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	// One instruction request.
	typedef struct packed {
		logic [FIELD_W-1:0] cmd;
		logic [FIELD_W-1:0] dest_reg;
		logic [FIELD_W-1:0] left_reg;
		logic [FIELD_W-1:0] right_operand;
	} instr_t;

	// One result.
	typedef struct packed {
		status_t                   status;
		logic [FIELD_W-1:0]        written_index;
		logic signed [DATA_W-1:0]  written_value;
	} result_t;

endpackage

// ===== rtl/rfae_stream_if.sv =====
// ----------------------------------------------------------------------------
// rfae_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface rfae_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/rfae_regfile.sv =====
// ----------------------------------------------------------------------------
// rfae_regfile
// Register file memory with one write port and two registered read ports.
// A per-entry valid bit, cleared by reset, makes unwritten entries read zero.
// ----------------------------------------------------------------------------
module rfae_regfile
	import rfae_pkg::*;
#(
	parameter int NUM_REGS = 16,
	parameter int IDX_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [IDX_W-1:0]  rd_a_addr,
	input  logic [IDX_W-1:0]  rd_b_addr,
	output logic [DATA_W-1:0] rd_a_data,
	output logic [DATA_W-1:0] rd_b_data
);

	logic [DATA_W-1:0] mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [DATA_W-1:0] rd_a_q;
	logic [DATA_W-1:0] rd_b_q;
	logic rd_a_vld_q;
	logic rd_b_vld_q;

	// Storage array and registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_a_addr];
		rd_b_q <= mem[rd_b_addr];
	end

	// Valid bits, cleared at reset, sampled together with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_a_vld_q <= valid_q[rd_a_addr];
			rd_b_vld_q <= valid_q[rd_b_addr];
		end
	end

	// An entry never written since reset reads as zero.
	assign rd_a_data = rd_a_vld_q ? rd_a_q : '0;
	assign rd_b_data = rd_b_vld_q ? rd_b_q : '0;

endmodule

// ===== rtl/rfae_divider.sv =====
// ----------------------------------------------------------------------------
// rfae_divider
// Iterative signed 32-bit divider, one restoring step per cycle. The
// quotient truncates toward zero; the most negative value over minus one
// wraps to itself.
// ----------------------------------------------------------------------------
module rfae_divider
	import rfae_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;
	logic [DATA_W-1:0] mag_a;
	logic [DATA_W-1:0] mag_b;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              fits;

	// Operand magnitudes at start.
	assign mag_a = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
	assign mag_b = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = !diff[DATA_W];

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

// ===== rtl/register_file_alu_executor_unit.sv =====
// ----------------------------------------------------------------------------
// register_file_alu_executor_unit
// Executes one 4-byte instruction per request against a register file and
// returns one result with status, written index and written value.
// ----------------------------------------------------------------------------
// Instructions are taken one at a time. An instruction that fails decode
// (unknown opcode or register index out of range) and a set go from the
// request straight to the done state; add, subtract and multiply pass
// through an execute state that uses the registered read of the register
// file. A divide by a nonzero value then waits for the 32 steps of the
// iterative divider. A finished result waits in an output register, so
// the next instruction can be taken while it is still pending. The register
// file reads zero after reset without a clearing pass.
// ----------------------------------------------------------------------------
module register_file_alu_executor_unit
	import rfae_pkg::*;
#(
	parameter int NUM_REGS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	rfae_stream_if.sink   instr,
	rfae_stream_if.source result
);

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam logic [FIELD_W:0] IDX_LIM = (FIELD_W + 1)'(NUM_REGS);

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_DONE
	} state_t;

	state_t  state_q;
	alu_op_t op_q;
	logic    imm_q;
	status_t status_q;
	logic [FIELD_W-1:0] dst_q;
	logic [FIELD_W-1:0] lft_q;
	logic [FIELD_W-1:0] rgt_q;
	logic [DATA_W-1:0]  value_q;
	logic               res_valid_q;
	result_t            res_q;

	instr_t  req;
	logic    accept;
	logic    known;
	logic    is_set;
	logic    is_imm;
	alu_op_t dec_op;
	logic    range_err;
	logic    out_free;

	logic [IDX_W-1:0]  rd_a_addr;
	logic [IDX_W-1:0]  rd_b_addr;
	logic [DATA_W-1:0] rd_a_data;
	logic [DATA_W-1:0] rd_b_data;
	logic [DATA_W-1:0] opnd_b;
	logic              wr_en;
	logic              div_start;
	logic              div_done;
	logic [DATA_W-1:0] div_q;

	assign req      = instr.data;
	assign accept   = instr.valid && instr.ready;
	assign out_free = !res_valid_q || result.ready;

	// Opcode decode.
	always_comb begin
		known  = 1'b1;
		is_set = 1'b0;
		is_imm = 1'b0;
		dec_op = ALU_ADD;
		case (req.cmd)
			OP_SET:   is_set = 1'b1;
			OP_ADD_R: dec_op = ALU_ADD;
			OP_ADD_I: begin dec_op = ALU_ADD; is_imm = 1'b1; end
			OP_SUB_R: dec_op = ALU_SUB;
			OP_SUB_I: begin dec_op = ALU_SUB; is_imm = 1'b1; end
			OP_MUL_R: dec_op = ALU_MUL;
			OP_MUL_I: begin dec_op = ALU_MUL; is_imm = 1'b1; end
			OP_DIV_R: dec_op = ALU_DIV;
			OP_DIV_I: begin dec_op = ALU_DIV; is_imm = 1'b1; end
			default:  known = 1'b0;
		endcase
	end

	// Index range check: destination always, left unless set, right in
	// register forms.
	always_comb begin
		range_err = ({1'b0, req.dest_reg} >= IDX_LIM);
		if (!is_set) begin
			range_err = range_err || ({1'b0, req.left_reg} >= IDX_LIM);
			if (!is_imm) begin
				range_err = range_err || ({1'b0, req.right_operand} >= IDX_LIM);
			end
		end
	end

	// Read addresses follow the incoming request while idle, so the operands
	// are ready in the cycle after it is taken; afterwards they hold.
	assign rd_a_addr = (state_q == S_IDLE) ? req.left_reg[IDX_W-1:0] : lft_q[IDX_W-1:0];
	assign rd_b_addr = (state_q == S_IDLE) ? req.right_operand[IDX_W-1:0]
	                                       : rgt_q[IDX_W-1:0];

	assign opnd_b    = imm_q ? DATA_W'(rgt_q) : rd_b_data;
	assign div_start = (state_q == S_EXEC) && (op_q == ALU_DIV) && (opnd_b != '0);
	assign wr_en     = (state_q == S_DONE) && out_free && (status_q == ST_OK);

	rfae_regfile #(
		.NUM_REGS (NUM_REGS),
		.IDX_W    (IDX_W)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (dst_q[IDX_W-1:0]),
		.wr_data   (value_q),
		.rd_a_addr (rd_a_addr),
		.rd_b_addr (rd_b_addr),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	rfae_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_a_data),
		.divisor  (opnd_b),
		.done     (div_done),
		.quotient (div_q)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			status_q    <= ST_OK;
			op_q        <= ALU_ADD;
			imm_q       <= 1'b0;
			dst_q       <= '0;
			lft_q       <= '0;
			rgt_q       <= '0;
			value_q     <= '0;
			res_q       <= '0;
		end else begin
			// A taken result frees the output register unless a new one lands now.
			if (result.valid && result.ready && !((state_q == S_DONE) && out_free)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= dec_op;
						imm_q    <= is_imm;
						dst_q    <= req.dest_reg;
						lft_q    <= req.left_reg;
						rgt_q    <= req.right_operand;
						value_q  <= DATA_W'(req.left_reg);
						if (!known) begin
							status_q <= ST_BADOP;
							state_q  <= S_DONE;
						end else if (range_err) begin
							status_q <= ST_RANGE;
							state_q  <= S_DONE;
						end else if (is_set) begin
							status_q <= ST_OK;
							state_q  <= S_DONE;
						end else begin
							status_q <= ST_OK;
							state_q  <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					case (op_q)
						ALU_ADD: begin
							value_q <= rd_a_data + opnd_b;
							state_q <= S_DONE;
						end
						ALU_SUB: begin
							value_q <= rd_a_data - opnd_b;
							state_q <= S_DONE;
						end
						ALU_MUL: begin
							value_q <= rd_a_data * opnd_b;
							state_q <= S_DONE;
						end
						default: begin
							if (opnd_b == '0) begin
								status_q <= ST_DIVZ;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						value_q <= div_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						res_valid_q  <= 1'b1;
						res_q.status <= status_q;
						if (status_q == ST_OK) begin
							res_q.written_index <= dst_q;
							res_q.written_value <= value_q;
						end else begin
							res_q.written_index <= '0;
							res_q.written_value <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign instr.ready  = (state_q == S_IDLE);
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule
